FILE: hw/rtl/rral_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rral_pkg
// shared types and constants of the per-class round-robin active list
// ----------------------------------------------------------------------------
package rral_pkg;

  localparam int MAX_CONNECTIONS = 256;
  localparam int NUM_CLASSES     = 5;
  localparam int CONN_W          = 8;
  localparam int CLASS_W         = 3;
  localparam int LINK_DEPTH      = NUM_CLASSES * MAX_CONNECTIONS;
  localparam int LINK_AW         = $clog2(LINK_DEPTH);
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_PW        = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    CMD_REGISTER   = 2'd0,
    CMD_SELECT     = 2'd1,
    CMD_ACTIVATE   = 2'd2,
    CMD_DEACTIVATE = 2'd3
  } cmd_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_UNKNOWN   = 2'd2;
  localparam logic [1:0] ST_DUPLICATE = 2'd3;

  typedef struct packed {
    cmd_t                cmd;
    logic [CONN_W-1:0]   conn;
    logic [CLASS_W-1:0]  cls;
    logic                cls_ok;
  } cmd_entry_t;

  typedef struct packed {
    logic       valid;
    cmd_entry_t entry;
  } queue_out_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              has_work;
    logic [CONN_W-1:0] gconn;
    logic              granted;
  } result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/per_class_round_robin_active_list.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// per_class_round_robin_active_list
// round-robin active connection lists, one per packet-type class
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one command transaction (register, select, mark active,
//           mark inactive) per handshake; a four-entry command queue
//           sits behind in_tready, so commands keep flowing while the
//           executing side works or the receiver stalls
//   out_* : exactly one result transaction per command, in order
// command flow:
//   an accepted command moves from the queue to the executing side's command
//   register, then to the result register on out_*; a new command is taken
//   only once the last result is taken, the pace set by the read-then-write
//   sequence on the single-port link memories; the second link write of a
//   rotating select or a mark active overlaps the result handshake
// reset: rst_n clears registrations and all class lists at once; the active
//   flags of a connection are cleared when it registers and the link
//   memories need no clearing
// stall: while out_tready is low the result holds and the executing side
//   waits; the queue fills and then in_tready drops
// ----------------------------------------------------------------------------
module per_class_round_robin_active_list import rral_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // command[1:0] connection[9:2] queue_class[12:10]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0] out_tdata        // granted[0] granted_connection[8:1]
                                       // class_has_work[9] status[11:10]
);

  queue_out_t q_out;
  logic       pop;

  rral_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .pop       (pop),
    .q_out     (q_out)
  );

  rral_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_in       (q_out),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/rral_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rral_front
// accepts command transactions, classifies them and queues them for the back
// ----------------------------------------------------------------------------
module rral_front import rral_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,
  input  wire logic        pop,
  output queue_out_t       q_out
);

  cmd_entry_t               mem_r [QUEUE_DEPTH];
  logic [QUEUE_PW-1:0]      wp_r, rp_r;
  logic [QUEUE_PW:0]        cnt_r;
  cmd_entry_t               ent;
  logic                     push, do_pop;

  always_comb begin
    ent.cmd    = cmd_t'(in_tdata[1:0]);
    ent.conn   = in_tdata[9:2];
    ent.cls    = in_tdata[12:10];
    ent.cls_ok = 32'(in_tdata[12:10]) < NUM_CLASSES;
  end

  assign in_tready   = cnt_r != (QUEUE_PW+1)'(QUEUE_DEPTH);
  assign push        = in_tvalid && in_tready;
  assign do_pop      = pop && (cnt_r != '0);
  assign q_out.valid = cnt_r != '0;
  assign q_out.entry = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QUEUE_PW+1)'(push) - (QUEUE_PW+1)'(do_pop);
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/rral_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rral_back
// executes queued commands against the link memories and class lists
// ----------------------------------------------------------------------------
module rral_back import rral_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  queue_out_t       q_in,
  output logic             pop,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_FIN} state_t;

  state_t                   state_r;
  cmd_entry_t               cur_r;
  logic [MAX_CONNECTIONS-1:0] reg_r, reg_nxt;
  logic [NUM_CLASSES-1:0]   act_mem [MAX_CONNECTIONS];
  logic [NUM_CLASSES-1:0]   act_rd_r;
  logic [CONN_W-1:0]        next_mem [LINK_DEPTH];
  logic [CONN_W-1:0]        prev_mem [LINK_DEPTH];
  logic [CONN_W-1:0]        next_rd_r, prev_rd_r;
  logic [CONN_W-1:0]        head_r [NUM_CLASSES];
  logic [CONN_W-1:0]        tail_r [NUM_CLASSES];
  logic [NUM_CLASSES-1:0]   ne_r, ne_nxt;
  logic [CONN_W-1:0]        head_nxt, tail_nxt;
  logic                     ht_we;
  logic [LINK_AW-1:0]       fin_addr_r, fin_addr_nxt;
  logic [CONN_W-1:0]        fin_data_r, fin_data_nxt;
  logic                     fin_nxt;
  logic                     out_valid_r;
  result_t                  res_r, res_nxt;
  logic [LINK_AW-1:0]       rd_addr, nw_addr, pw_addr;
  logic [CONN_W-1:0]        nw_data, pw_data;
  logic                     nw_en, pw_en, aw_en;
  logic [LINK_AW-1:0]       aw_unused;
  logic [NUM_CLASSES-1:0]   aw_data;
  logic [CLASS_W-1:0]       qi;
  logic [CONN_W-1:0]        h, t;
  logic                     ne, known;

  function automatic logic [LINK_AW-1:0] laddr(logic [CLASS_W-1:0] q, logic [CONN_W-1:0] c);
    laddr = LINK_AW'(32'(q) * MAX_CONNECTIONS + 32'(c));
  endfunction

  assign pop        = (state_r == S_IDLE) && !out_valid_r && q_in.valid;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, res_r};
  assign aw_unused  = '0;

  always_comb begin
    rd_addr = '0;
    if (q_in.entry.cls_ok) begin
      if (q_in.entry.cmd == CMD_SELECT) begin
        rd_addr = laddr(q_in.entry.cls, head_r[q_in.entry.cls]);
      end else begin
        rd_addr = laddr(q_in.entry.cls, q_in.entry.conn);
      end
    end
  end

  always_comb begin
    qi        = cur_r.cls_ok ? cur_r.cls : '0;
    h         = head_r[qi];
    t         = tail_r[qi];
    ne        = cur_r.cls_ok && ne_r[qi];
    known     = (32'(cur_r.conn) < MAX_CONNECTIONS) && reg_r[cur_r.conn];
    reg_nxt   = reg_r;
    ne_nxt    = ne_r;
    head_nxt  = h;
    tail_nxt  = t;
    ht_we     = 1'b0;
    nw_en     = 1'b0;
    nw_addr   = '0;
    nw_data   = '0;
    pw_en     = 1'b0;
    pw_addr   = '0;
    pw_data   = '0;
    aw_en     = 1'b0;
    aw_data   = act_rd_r;
    fin_nxt   = 1'b0;
    fin_addr_nxt = aw_unused;
    fin_data_nxt = '0;
    res_nxt   = '0;
    res_nxt.status = ST_OK;
    case (cur_r.cmd)
      CMD_REGISTER: begin
        if (!(32'(cur_r.conn) < MAX_CONNECTIONS)) begin
          res_nxt.status = ST_UNKNOWN;
        end else if (reg_r[cur_r.conn]) begin
          res_nxt.status = ST_DUPLICATE;
        end else begin
          reg_nxt[cur_r.conn] = 1'b1;
          aw_en   = 1'b1;
          aw_data = '0;
        end
      end
      CMD_SELECT: begin
        if (!ne) begin
          res_nxt.status = ST_EMPTY;
        end else begin
          res_nxt.granted = 1'b1;
          res_nxt.gconn   = h;
          if (t != h) begin
            ht_we    = 1'b1;
            head_nxt = next_rd_r;
            tail_nxt = h;
            nw_en    = 1'b1;
            nw_addr  = laddr(qi, t);
            nw_data  = h;
            pw_en    = 1'b1;
            pw_addr  = laddr(qi, h);
            pw_data  = t;
            fin_nxt  = 1'b1;
            fin_addr_nxt = laddr(qi, h);
            fin_data_nxt = h;
          end
        end
      end
      CMD_ACTIVATE: begin
        if (!known) begin
          res_nxt.status = ST_UNKNOWN;
        end else if (cur_r.cls_ok && !act_rd_r[qi]) begin
          aw_en       = 1'b1;
          aw_data[qi] = 1'b1;
          ht_we       = 1'b1;
          tail_nxt    = cur_r.conn;
          pw_en       = 1'b1;
          pw_addr     = laddr(qi, cur_r.conn);
          if (ne) begin
            nw_en   = 1'b1;
            nw_addr = laddr(qi, t);
            nw_data = cur_r.conn;
            pw_data = t;
          end else begin
            head_nxt   = cur_r.conn;
            pw_data    = cur_r.conn;
            ne_nxt[qi] = 1'b1;
          end
          fin_nxt      = 1'b1;
          fin_addr_nxt = laddr(qi, cur_r.conn);
          fin_data_nxt = cur_r.conn;
        end
      end
      CMD_DEACTIVATE: begin
        if (!known) begin
          res_nxt.status = ST_UNKNOWN;
        end else if (cur_r.cls_ok && act_rd_r[qi]) begin
          aw_en       = 1'b1;
          aw_data[qi] = 1'b0;
          ht_we       = 1'b1;
          if ((h == cur_r.conn) && (t == cur_r.conn)) begin
            ne_nxt[qi] = 1'b0;
          end else if (h == cur_r.conn) begin
            head_nxt = next_rd_r;
          end else if (t == cur_r.conn) begin
            tail_nxt = prev_rd_r;
          end else begin
            nw_en   = 1'b1;
            nw_addr = laddr(qi, prev_rd_r);
            nw_data = next_rd_r;
            pw_en   = 1'b1;
            pw_addr = laddr(qi, next_rd_r);
            pw_data = prev_rd_r;
          end
        end
      end
      default: begin
        res_nxt.status = ST_OK;
      end
    endcase
    res_nxt.has_work = cur_r.cls_ok && ne_nxt[qi];
  end

  // next-link memory: exec write or fin write, one port
  always_ff @(posedge clk) begin
    if (state_r == S_FIN) begin
      next_mem[fin_addr_r] <= fin_data_r;
    end else if (state_r == S_EXEC && nw_en) begin
      next_mem[nw_addr] <= nw_data;
    end
    if (pop) begin
      next_rd_r <= next_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EXEC && pw_en) begin
      prev_mem[pw_addr] <= pw_data;
    end
    if (pop) begin
      prev_rd_r <= prev_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EXEC && aw_en) begin
      act_mem[cur_r.conn] <= aw_data;
    end
    if (pop) begin
      act_rd_r <= act_mem[q_in.entry.conn];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EXEC && ht_we) begin
      head_r[qi] <= head_nxt;
      tail_r[qi] <= tail_nxt;
    end
    if (pop) begin
      cur_r <= q_in.entry;
    end
    if (state_r == S_EXEC) begin
      res_r      <= res_nxt;
      fin_addr_r <= fin_addr_nxt;
      fin_data_r <= fin_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      reg_r       <= '0;
      ne_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (pop) state_r <= S_EXEC;
        end
        S_EXEC: begin
          reg_r       <= reg_nxt;
          ne_r        <= ne_nxt;
          out_valid_r <= 1'b1;
          state_r     <= fin_nxt ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/rral_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rral_checker
// port-level checks of the active list result stream
// ----------------------------------------------------------------------------
module rral_checker import rral_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [15:0] in_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata
);

  logic unused_in;
  assign unused_in = in_tvalid ^ in_tready ^ (^in_tdata);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[11:10] == ST_OK && out_tdata[9])
    else $error("grant without ok status and work");

  a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[8:1] == 8'd0)
    else $error("connection reported without grant");

endmodule

bind per_class_round_robin_active_list rral_checker u_rral_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
